@@ rtl/frqk_pkg.sv @@
// frqk_pkg: shared widths, operation codes, status codes and register indexes
// for the frame ring queue with keep-last mode; no dependencies
package frqk_pkg;

	localparam int OP_W        = 3;
	localparam int SERIAL_W    = 31;
	localparam int POS_W       = 48;
	localparam int LPOS_W      = 49;
	localparam int STATUS_W    = 2;
	localparam int SLOT_OUT_W  = 4;
	localparam int REMAIN_W    = 5;
	localparam int QDEPTH_W    = 5;
	localparam int CFG_IDX_W   = 1;
	localparam int ENTRY_W     = SERIAL_W + POS_W;
	localparam int IN_FIELDS_W = OP_W + SERIAL_W + POS_W + SERIAL_W + 1;
	localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = STATUS_W + SLOT_OUT_W + SERIAL_W + POS_W + REMAIN_W + LPOS_W;
	localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [OP_W-1:0] OP_PUSH      = 3'd0;
	localparam logic [OP_W-1:0] OP_NEXT      = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK_READ = 3'd2;
	localparam logic [OP_W-1:0] OP_PEEK_NEXT = 3'd3;
	localparam logic [OP_W-1:0] OP_PEEK_LAST = 3'd4;
	localparam logic [OP_W-1:0] OP_STATUS    = 3'd5;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_ABORT = 2'd3
	} status_t;

	localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_DEPTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LAST   = 1'b1;

	localparam logic [LPOS_W-1:0] LPOS_NONE = '1;

endpackage

@@ rtl/frqk_ram.sv @@
// frqk_ram: generic single write port, single read port memory with
// registered read data; no dependencies
module frqk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/frqk_ptr_mod.sv @@
// frqk_ptr_mod: bit-serial remainder unit that reduces two ring pointers
// modulo a new depth, one quotient bit per cycle; no dependencies
module frqk_ptr_mod #(
	parameter int PW = 4,
	parameter int DW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] den,
	input  logic [PW-1:0] num_a,
	input  logic [PW-1:0] num_b,
	output logic          busy,
	output logic          done,
	output logic [PW-1:0] rem_a,
	output logic [PW-1:0] rem_b
);

	localparam int AW = PW + 1;
	localparam int CW = $clog2(PW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] den_q;
	logic [PW-1:0] na_q, nb_q;
	logic [PW-1:0] ra_q, rb_q;
	logic [AW-1:0] ta, tb, den_a;

	always_comb begin
		den_a = AW'(den_q);
		ta = {ra_q, na_q[PW-1]};
		tb = {rb_q, nb_q[PW-1]};
		if (ta >= den_a) begin
			ta = ta - den_a;
		end
		if (tb >= den_a) begin
			tb = tb - den_a;
		end
	end

	assign busy  = busy_q;
	assign done  = busy_q && (cnt_q == CW'(1));
	assign rem_a = PW'(ta);
	assign rem_b = PW'(tb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(PW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			na_q  <= num_a;
			nb_q  <= num_b;
			ra_q  <= '0;
			rb_q  <= '0;
		end else if (busy_q) begin
			na_q <= na_q << 1;
			nb_q <= nb_q << 1;
			ra_q <= PW'(ta);
			rb_q <= PW'(tb);
		end
	end

endmodule

@@ rtl/frame_ring_queue_keep_last.sv @@
// frame_ring_queue_keep_last: top level of the frame descriptor ring queue
// depends on frqk_pkg, frqk_ram and frqk_ptr_mod
//
// One request is taken per cycle unless a config write is pending, the remainder
// unit is busy or the master side stalls; its result passes through one internal
// stage (stage 1) and the output register, which let a new request enter while an
// earlier result still waits. The descriptors live in two mirrored memories of
// DEPTH slots with registered read, one for the slot a request addresses and one
// for the slot at the read pointer after the request. A write of queue_depth
// starts a bit-serial remainder unit that reduces both pointers modulo the new
// depth; while it runs, neither requests nor config writes are taken.
module frame_ring_queue_keep_last
	import frqk_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [QDEPTH_W-1:0]     cfg_data,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// op, frame_serial, frame_pos, current_serial, abort_flag
	input  logic [IN_DATA_W-1:0]    s_axis_tdata,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// status, slot_index, entry_serial, entry_pos, remaining_count, last_shown_pos
	output logic [OUT_DATA_W-1:0]   m_axis_tdata
);

	localparam int PW = $clog2(DEPTH);
	localparam int DW = $clog2(DEPTH + 1);
	localparam int AW = PW + 1;
	localparam int D_RST = (DEPTH < 16) ? DEPTH : 16;

	function automatic logic [DW-1:0] eff_depth(input logic [QDEPTH_W-1:0] qd);
		logic [DW-1:0] r;
		if (qd == '0) begin
			r = DW'(1);
		end else if (32'(qd) > DEPTH) begin
			r = DW'(DEPTH);
		end else begin
			r = DW'(qd);
		end
		return r;
	endfunction

	// input fields
	logic [OP_W-1:0]     op;
	logic [SERIAL_W-1:0] frame_serial;
	logic [POS_W-1:0]    frame_pos;
	logic [SERIAL_W-1:0] current_serial;
	logic                abort_flag;

	assign op             = s_axis_tdata[OP_W-1:0];
	assign frame_serial   = s_axis_tdata[OP_W +: SERIAL_W];
	assign frame_pos      = s_axis_tdata[OP_W+SERIAL_W +: POS_W];
	assign current_serial = s_axis_tdata[OP_W+SERIAL_W+POS_W +: SERIAL_W];
	assign abort_flag     = s_axis_tdata[OP_W+2*SERIAL_W+POS_W];

	// state
	logic [DW-1:0] depth_q;
	logic          keep_last_q;
	logic [PW-1:0] rd_raw_q, wr_raw_q, rd_red_q, wr_red_q;
	logic [DW-1:0] fill_q;
	logic          shown_q;

	// pipeline
	logic                s1_valid_q;
	status_t             st_s1;
	logic [PW-1:0]       slot_s1;
	logic                rep_push_s1, rep_ram_s1, lchk_s1, fwd_s1;
	logic [SERIAL_W-1:0] cser_s1, push_ser_s1;
	logic [POS_W-1:0]    push_pos_s1;
	logic [REMAIN_W-1:0] rem_s1;
	logic                m_valid_q;
	logic [OUT_DATA_W-1:0] out_q;

	// handshakes
	logic in_acc, cfg_acc, s1_adv, mod_start, mod_busy, mod_done;
	logic [PW-1:0] mod_rem_a, mod_rem_b;

	// decode
	status_t       st;
	logic [PW-1:0] slot, rs_n, adv_rs, adv_wr, peek0, peek1;
	logic          rep_push, rep_ram, do_push, do_adv, set_shown;
	logic [DW-1:0] unsh, fill_n, unsh_n;
	logic          sh_n;
	logic [AW-1:0] d_a, x0, x1, ra, wa;

	assign s1_adv        = s1_valid_q && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !mod_busy && !cfg_valid && (!s1_valid_q || s1_adv);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = !mod_busy;
	assign cfg_acc       = cfg_valid && cfg_ready;
	assign mod_start     = cfg_acc && (cfg_index == CFG_QUEUE_DEPTH);

	always_comb begin
		d_a = AW'(depth_q);
		ra  = AW'(rd_red_q) + AW'(1);
		wa  = AW'(wr_red_q) + AW'(1);
		adv_rs = (ra >= d_a) ? '0 : PW'(ra);
		adv_wr = (wa >= d_a) ? '0 : PW'(wa);
		x0 = AW'(rd_red_q) + AW'(shown_q);
		x1 = x0 + AW'(1);
		if (x0 >= d_a) begin
			x0 = x0 - d_a;
		end
		if (x1 >= d_a) begin
			x1 = x1 - d_a;
		end
		peek0 = (depth_q == DW'(1)) ? '0 : PW'(x0);
		peek1 = (depth_q == DW'(1)) ? '0 : PW'(x1);
		unsh  = (fill_q > DW'(shown_q)) ? fill_q - DW'(shown_q) : '0;
	end

	always_comb begin
		st        = ST_OK;
		slot      = '0;
		rep_push  = 1'b0;
		rep_ram   = 1'b0;
		do_push   = 1'b0;
		do_adv    = 1'b0;
		set_shown = 1'b0;
		case (op)
			OP_PUSH: begin
				if (abort_flag) begin
					st = ST_ABORT;
				end else if (fill_q >= depth_q) begin
					st = ST_FULL;
				end else begin
					slot     = wr_red_q;
					rep_push = 1'b1;
					do_push  = 1'b1;
				end
			end
			OP_NEXT: begin
				if (fill_q == '0) begin
					st = ST_EMPTY;
				end else begin
					slot    = rd_red_q;
					rep_ram = 1'b1;
					if (keep_last_q && !shown_q) begin
						set_shown = 1'b1;
					end else begin
						do_adv = 1'b1;
					end
				end
			end
			OP_PEEK_READ: begin
				if (abort_flag) begin
					st = ST_ABORT;
				end else if (unsh == '0) begin
					st = ST_EMPTY;
				end else begin
					slot    = peek0;
					rep_ram = 1'b1;
				end
			end
			OP_PEEK_NEXT: begin
				if (abort_flag) begin
					st = ST_ABORT;
				end else if (unsh < DW'(2)) begin
					st = ST_EMPTY;
				end else begin
					slot    = peek1;
					rep_ram = 1'b1;
				end
			end
			OP_PEEK_LAST: begin
				if (abort_flag) begin
					st = ST_ABORT;
				end else if (fill_q == '0) begin
					st = ST_EMPTY;
				end else begin
					slot    = rd_red_q;
					rep_ram = 1'b1;
				end
			end
			default: begin
				st      = abort_flag ? ST_ABORT : ST_OK;
				slot    = rd_red_q;
				rep_ram = (fill_q != '0);
			end
		endcase
	end

	always_comb begin
		fill_n = fill_q;
		if (do_push) begin
			fill_n = fill_q + DW'(1);
		end else if (do_adv) begin
			fill_n = fill_q - DW'(1);
		end
		sh_n   = shown_q | set_shown;
		rs_n   = do_adv ? adv_rs : rd_red_q;
		unsh_n = (fill_n > DW'(sh_n)) ? fill_n - DW'(sh_n) : '0;
	end

	// memories: a serves the addressed slot, b the slot at the read pointer
	logic [ENTRY_W-1:0] ram_wdata, ram_a_rdata, ram_b_rdata;
	logic               ram_we;

	assign ram_we    = in_acc && do_push;
	assign ram_wdata = {frame_pos, frame_serial};

	frqk_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_red_q),
		.wdata (ram_wdata),
		.re    (in_acc),
		.raddr (slot),
		.rdata (ram_a_rdata)
	);

	frqk_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_red_q),
		.wdata (ram_wdata),
		.re    (in_acc),
		.raddr (rs_n),
		.rdata (ram_b_rdata)
	);

	frqk_ptr_mod #(.PW(PW), .DW(DW)) u_ptr_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.den    (eff_depth(cfg_data)),
		.num_a  (rd_raw_q),
		.num_b  (wr_raw_q),
		.busy   (mod_busy),
		.done   (mod_done),
		.rem_a  (mod_rem_a),
		.rem_b  (mod_rem_b)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= DW'(D_RST);
			keep_last_q <= 1'b1;
			rd_raw_q    <= '0;
			wr_raw_q    <= '0;
			rd_red_q    <= '0;
			wr_red_q    <= '0;
			fill_q      <= '0;
			shown_q     <= 1'b0;
			s1_valid_q  <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_acc) begin
				case (cfg_index)
					CFG_QUEUE_DEPTH: depth_q     <= eff_depth(cfg_data);
					CFG_KEEP_LAST:   keep_last_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (mod_done) begin
				rd_red_q <= mod_rem_a;
				wr_red_q <= mod_rem_b;
			end else if (in_acc) begin
				if (do_adv) begin
					rd_raw_q <= adv_rs;
					rd_red_q <= adv_rs;
				end
				if (do_push) begin
					wr_raw_q <= adv_wr;
					wr_red_q <= adv_wr;
				end
				fill_q  <= fill_n;
				shown_q <= sh_n;
			end
			if (in_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			st_s1       <= st;
			slot_s1     <= slot;
			rep_push_s1 <= rep_push;
			rep_ram_s1  <= rep_ram;
			lchk_s1     <= sh_n && (fill_n != '0);
			fwd_s1      <= do_push && (wr_red_q == rs_n);
			cser_s1     <= current_serial;
			push_ser_s1 <= frame_serial;
			push_pos_s1 <= frame_pos;
			rem_s1      <= REMAIN_W'(unsh_n);
		end
	end

	logic [SERIAL_W-1:0] ent_ser, b_ser;
	logic [POS_W-1:0]    ent_pos, b_pos;
	logic [LPOS_W-1:0]   lpos;

	always_comb begin
		if (rep_push_s1) begin
			ent_ser = push_ser_s1;
			ent_pos = push_pos_s1;
		end else if (rep_ram_s1) begin
			ent_ser = ram_a_rdata[SERIAL_W-1:0];
			ent_pos = ram_a_rdata[SERIAL_W +: POS_W];
		end else begin
			ent_ser = '0;
			ent_pos = '0;
		end
		if (fwd_s1) begin
			b_ser = push_ser_s1;
			b_pos = push_pos_s1;
		end else begin
			b_ser = ram_b_rdata[SERIAL_W-1:0];
			b_pos = ram_b_rdata[SERIAL_W +: POS_W];
		end
		lpos = (lchk_s1 && (b_ser == cser_s1)) ? {1'b0, b_pos} : LPOS_NONE;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q <= OUT_DATA_W'({lpos, rem_s1, ent_pos, ent_ser,
				SLOT_OUT_W'(slot_s1), st_s1});
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_q;

endmodule

@@ test/frame_ring_queue_keep_last_checker.sv @@
// frame_ring_queue_keep_last_checker: watches the config, request and result channels of the
// frame ring queue, predicts every result and compares it field by field
// depends on frqk_pkg
module frame_ring_queue_keep_last_checker
	import frqk_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [QDEPTH_W-1:0]   cfg_data,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	output int                    fail_count,
	output int                    pending
);

	localparam int I_SER   = OP_W;
	localparam int I_POS   = I_SER + SERIAL_W;
	localparam int I_CSER  = I_POS + POS_W;
	localparam int I_ABORT = I_CSER + SERIAL_W;

	localparam int O_SLOT = STATUS_W;
	localparam int O_SER  = O_SLOT + SLOT_OUT_W;
	localparam int O_POS  = O_SER + SERIAL_W;
	localparam int O_REM  = O_POS + POS_W;
	localparam int O_LPOS = O_REM + REMAIN_W;

	typedef struct {
		status_t                status;
		logic [SLOT_OUT_W-1:0]  slot;
		logic [SERIAL_W-1:0]    serial;
		logic [POS_W-1:0]       pos;
		logic [REMAIN_W-1:0]    remain;
		logic [LPOS_W-1:0]      lpos;
	} op_result_t;

	logic [SERIAL_W-1:0] slot_serial [DEPTH];
	logic [POS_W-1:0]    slot_pos [DEPTH];
	int unsigned         rd_ptr;
	int unsigned         wr_ptr;
	int unsigned         fill;
	int unsigned         shown;
	logic [QDEPTH_W-1:0] depth_reg;
	logic                hold_mode;
	op_result_t          awaited_results [$];
	int                  mismatches;

	function automatic int unsigned eff_depth();
		int unsigned d;
		d = depth_reg;
		if (d < 1) d = 1;
		if (d > DEPTH) d = DEPTH;
		return d;
	endfunction

	function automatic int unsigned step_ptr(input int unsigned p, input int unsigned d);
		int unsigned n;
		n = (p % d) + 1;
		return (n >= d) ? 0 : n;
	endfunction

	function automatic int unsigned unshown_count();
		return (fill > shown) ? fill - shown : 0;
	endfunction

	function automatic void take_slot(inout op_result_t r, input int unsigned s);
		r.slot = SLOT_OUT_W'(s);
		r.serial = slot_serial[s];
		r.pos = slot_pos[s];
	endfunction

	function automatic op_result_t predict_op_result(input logic [IN_DATA_W-1:0] req);
		op_result_t          r;
		logic [OP_W-1:0]     op;
		logic [SERIAL_W-1:0] fser;
		logic [SERIAL_W-1:0] cser;
		logic [POS_W-1:0]    fpos;
		logic                ab;
		int unsigned         d;
		int unsigned         rs;
		int unsigned         w;
		op = req[OP_W-1:0];
		fser = req[I_SER +: SERIAL_W];
		fpos = req[I_POS +: POS_W];
		cser = req[I_CSER +: SERIAL_W];
		ab = req[I_ABORT];
		d = eff_depth();
		rs = rd_ptr % d;
		r.status = ST_OK;
		r.slot = '0;
		r.serial = '0;
		r.pos = '0;
		case (op)
			OP_PUSH: begin
				if (ab) r.status = ST_ABORT;
				else if (fill >= d) r.status = ST_FULL;
				else begin
					w = wr_ptr % d;
					slot_serial[w] = fser;
					slot_pos[w] = fpos;
					take_slot(r, w);
					wr_ptr = step_ptr(wr_ptr, d);
					fill++;
				end
			end
			OP_NEXT: begin
				if (fill == 0) r.status = ST_EMPTY;
				else begin
					take_slot(r, rs);
					if (hold_mode && shown == 0) shown = 1;
					else begin
						rd_ptr = step_ptr(rd_ptr, d);
						fill--;
					end
				end
			end
			OP_PEEK_READ: begin
				if (ab) r.status = ST_ABORT;
				else if (unshown_count() == 0) r.status = ST_EMPTY;
				else take_slot(r, (rd_ptr + shown) % d);
			end
			OP_PEEK_NEXT: begin
				if (ab) r.status = ST_ABORT;
				else if (unshown_count() < 2) r.status = ST_EMPTY;
				else take_slot(r, (rd_ptr + shown + 1) % d);
			end
			OP_PEEK_LAST: begin
				if (ab) r.status = ST_ABORT;
				else if (fill == 0) r.status = ST_EMPTY;
				else take_slot(r, rs);
			end
			default: begin
				r.status = ab ? ST_ABORT : ST_OK;
				r.slot = SLOT_OUT_W'(rs);
				if (fill != 0) take_slot(r, rs);
			end
		endcase
		r.remain = REMAIN_W'(unshown_count());
		rs = rd_ptr % d;
		if (shown != 0 && fill != 0 && slot_serial[rs] == cser) r.lpos = {1'b0, slot_pos[rs]};
		else r.lpos = LPOS_NONE;
		return r;
	endfunction

	function automatic op_result_t unpack_result(input logic [OUT_DATA_W-1:0] t);
		op_result_t r;
		r.status = status_t'(t[STATUS_W-1:0]);
		r.slot = t[O_SLOT +: SLOT_OUT_W];
		r.serial = t[O_SER +: SERIAL_W];
		r.pos = t[O_POS +: POS_W];
		r.remain = t[O_REM +: REMAIN_W];
		r.lpos = t[O_LPOS +: LPOS_W];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		op_result_t got;
		op_result_t want;
		if (!arst_n) begin
			foreach (slot_serial[i]) begin
				slot_serial[i] = '0;
				slot_pos[i] = '0;
			end
			rd_ptr = 0;
			wr_ptr = 0;
			fill = 0;
			shown = 0;
			depth_reg = 5'd16;
			hold_mode = 1'b1;
			awaited_results.delete();
			mismatches = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = unpack_result(m_axis_tdata);
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"unexpected result at %0t: st=%0d slot=%0d",
							" ser=%h pos=%h rem=%0d lpos=%h"},
							$realtime, got.status, got.slot, got.serial, got.pos,
							got.remain, got.lpos);
				end else begin
					want = awaited_results.pop_front();
					if (got.status !== want.status || got.slot !== want.slot ||
							got.serial !== want.serial || got.pos !== want.pos ||
							got.remain !== want.remain || got.lpos !== want.lpos) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch at %0t", $realtime);
							$display("  want st=%0d slot=%0d ser=%h pos=%h rem=%0d lpos=%h",
								want.status, want.slot, want.serial, want.pos, want.remain, want.lpos);
							$display("  got  st=%0d slot=%0d ser=%h pos=%h rem=%0d lpos=%h",
								got.status, got.slot, got.serial, got.pos, got.remain, got.lpos);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_QUEUE_DEPTH) depth_reg = cfg_data;
				else if (cfg_index == CFG_KEEP_LAST) hold_mode = cfg_data[0];
			end
			if (s_axis_tvalid && s_axis_tready)
				awaited_results.push_back(predict_op_result(s_axis_tdata));
			pending <= awaited_results.size();
			fail_count <= mismatches;
		end
	end

endmodule

@@ test/frame_ring_queue_keep_last_test.sv @@
// frame_ring_queue_keep_last_test: drives requests, config writes and result stalls into the
// frame ring queue and reports the verdict of the checker beside it
// depends on frqk_pkg, frame_ring_queue_keep_last and frame_ring_queue_keep_last_checker
module frame_ring_queue_keep_last_test;
	import frqk_pkg::*;

	localparam int QDEPTH        = 16;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_ITEMS   = 130;
	localparam int PHASES        = 10;

	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

	localparam logic [SERIAL_W-1:0] SER_MAX = '1;
	localparam logic [POS_W-1:0]    POS_MAX = '1;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [QDEPTH_W-1:0]   cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	int                    fail_count;
	int                    pending;
	int                    rx_wait = 0;
	logic                  rx_calm = 1'b0;
	logic                  tx_calm = 1'b0;
	logic [SERIAL_W-1:0]   last_serial = '0;

	logic [QDEPTH_W-1:0] phase_depth [PHASES] = '{5'd4, 5'd1, 5'd16, 5'd2, 5'd0,
		5'd31, 5'd7, 5'd16, 5'd3, 5'd12};
	logic phase_keep [PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

	frame_ring_queue_keep_last #(
		.DEPTH(QDEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	frame_ring_queue_keep_last_checker #(
		.DEPTH(QDEPTH)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #5 clk = ~clk;

	// result side: stall for a drawn number of cycles after each accepted result
	always @(posedge clk or negedge arst_n) begin : rx_side
		int w;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			w = rx_calm ? 0 : $urandom_range(0, 15);
			rx_wait <= w;
			m_axis_tready <= (w == 0);
		end else if (!m_axis_tready) begin
			if (rx_wait <= 1) m_axis_tready <= 1'b1;
			rx_wait <= rx_wait - 1;
		end
	end

	function automatic logic [IN_DATA_W-1:0] pack_request(input logic [OP_W-1:0] op,
			input logic [SERIAL_W-1:0] fser, input logic [POS_W-1:0] fpos,
			input logic [SERIAL_W-1:0] cser, input logic ab);
		return {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, ab, cser, fpos, fser, op};
	endfunction

	function automatic logic [SERIAL_W-1:0] rand_serial();
		case ($urandom_range(0, 3))
			0, 1: return SERIAL_W'($urandom_range(0, 3));
			2: return SERIAL_W'($urandom);
			default: return $urandom_range(0, 1) ? SER_MAX : '0;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] rand_pos();
		case ($urandom_range(0, 3))
			0: return POS_W'($urandom_range(0, 255));
			1, 2: return POS_W'({$urandom, $urandom});
			default: return $urandom_range(0, 1) ? POS_MAX : '0;
		endcase
	endfunction

	function automatic logic [OP_W-1:0] pick_op(input int push_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < push_pct) return OP_PUSH;
		if (r < push_pct + 25) return OP_NEXT;
		if (r < 76) return OP_PEEK_READ;
		if (r < 82) return OP_PEEK_NEXT;
		if (r < 88) return OP_PEEK_LAST;
		if (r < 96) return OP_STATUS;
		return $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
	endfunction

	task automatic send_request(input logic [IN_DATA_W-1:0] req);
		int gap;
		s_axis_tdata <= req;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		gap = tx_calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_op(input logic [OP_W-1:0] op, input logic [SERIAL_W-1:0] fser,
			input logic [POS_W-1:0] fpos, input logic [SERIAL_W-1:0] cser, input logic ab);
		send_request(pack_request(op, fser, fpos, cser, ab));
	endtask

	task automatic send_random(input int push_pct);
		logic [OP_W-1:0]     op;
		logic [SERIAL_W-1:0] fser;
		logic [SERIAL_W-1:0] cser;
		op = pick_op(push_pct);
		fser = rand_serial();
		cser = $urandom_range(0, 1) ? last_serial : rand_serial();
		if (op == OP_PUSH) last_serial = fser;
		send_op(op, fser, rand_pos(), cser, $urandom_range(0, 9) == 0);
	endtask

	// lower the request valid and wait until every result is back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [QDEPTH_W-1:0] depth, input logic keep);
		cfg_index <= CFG_QUEUE_DEPTH;
		cfg_data <= depth;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_KEEP_LAST;
		cfg_data <= {{(QDEPTH_W - 1){1'b0}}, keep};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		#5000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		int push_pct;
		int pause_at;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue cases, then fill every slot so no later read hits an unwritten one
		send_op(OP_STATUS, '0, '0, '0, 1'b1);
		send_op(OP_NEXT, '0, '0, '0, 1'b0);
		send_op(OP_PEEK_READ, '0, '0, SER_MAX, 1'b0);
		send_op(OP_PUSH, SER_MAX, POS_MAX, '0, 1'b1);
		send_op(OP_PUSH, '0, '0, '0, 1'b0);
		send_op(OP_PUSH, SER_MAX, POS_MAX, '0, 1'b0);
		send_op(OP_PUSH, '0, POS_MAX, SER_MAX, 1'b0);
		for (int i = 3; i < QDEPTH; i++) send_op(OP_PUSH, rand_serial(), rand_pos(), '0, 1'b0);
		send_op(OP_PUSH, SER_MAX, POS_MAX, '0, 1'b0);
		send_op(OP_PEEK_NEXT, '0, '0, '0, 1'b0);
		send_op(OP_PEEK_LAST, '0, '0, '0, 1'b1);
		send_op(OP_NEXT, '0, '0, '0, 1'b0);
		send_op(OP_SPARE_A, '0, '0, '0, 1'b0);
		send_op(OP_NEXT, '0, '0, SER_MAX, 1'b0);
		send_op(OP_SPARE_B, '0, '0, SER_MAX, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			if (p == PHASES - 1)
				apply_settings(QDEPTH_W'($urandom_range(1, 16)), 1'($urandom_range(0, 1)));
			else apply_settings(phase_depth[p], phase_keep[p]);
			push_pct = $urandom_range(20, 45);
			pause_at = $urandom_range(10, PHASE_ITEMS - 10);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
				if ($urandom_range(0, 39) == 0) rx_calm <= !rx_calm;
				if (i == pause_at) wait_drained();
				send_random(push_pct);
			end
		end

		wait_drained();
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ frame_ring_queue_keep_last.f @@
rtl/frqk_pkg.sv
rtl/frqk_ram.sv
rtl/frqk_ptr_mod.sv
rtl/frame_ring_queue_keep_last.sv
test/frame_ring_queue_keep_last_checker.sv
test/frame_ring_queue_keep_last_test.sv
